@@ sv/cdq_pkg.sv @@
`timescale 1ns / 1ps

package cdq_pkg;

  localparam int DATA_W = 32;

  // Command codes as they arrive on the request channel.
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_REAR  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_REAR   = 3'd3;
  localparam logic [2:0] CMD_READ_ALL   = 3'd4;

  // Decoded operation kinds handed from the front end to the engine.
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]               cmd;
    logic signed [DATA_W-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic [1:0]               status;
    logic                     last;
  } rsp_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic                     at_front;
    logic signed [DATA_W-1:0] data;
  } op_t;

endpackage

@@ sv/cdq_front.sv @@
`timescale 1ns / 1ps

module cdq_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  cdq_pkg::req_t req,
  output logic          op_valid,
  input  logic          op_take,
  output cdq_pkg::op_t  op
);
  import cdq_pkg::*;

  op_t        slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       known;
  logic       push;
  logic       pop;
  op_t        dec;

  always_comb begin
    dec          = '0;
    dec.data     = req.data_in;
    dec.at_front = 1'b0;
    known        = 1'b1;
    unique case (req.cmd)
      CMD_PUSH_FRONT: begin
        dec.kind     = OP_PUSH;
        dec.at_front = 1'b1;
      end
      CMD_PUSH_REAR: begin
        dec.kind = OP_PUSH;
      end
      CMD_POP_FRONT: begin
        dec.kind     = OP_POP;
        dec.at_front = 1'b1;
      end
      CMD_POP_REAR: begin
        dec.kind = OP_POP;
      end
      CMD_READ_ALL: begin
        dec.kind = OP_READ;
      end
      default: begin
        // Unused codes are taken and dropped without a result.
        known = 1'b0;
      end
    endcase
  end

  assign req_ready = (count != 2'd2);
  assign push      = req_valid && req_ready && known;
  assign op_valid  = (count != 2'd0);
  assign pop       = op_valid && op_take;
  assign op        = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

@@ sv/cdq_engine.sv @@
`timescale 1ns / 1ps

module cdq_engine #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  output logic          op_take,
  input  cdq_pkg::op_t  op,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output cdq_pkg::rsp_t rsp
);
  import cdq_pkg::*;

  localparam int AW = $clog2(DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] i);
    return (i == '0) ? AW'(DEPTH - 1) : i - AW'(1);
  endfunction

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata;

  logic [1:0]    state, state_next;
  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail, tail_next;
  logic          empty, empty_next;
  logic [AW-1:0] scan, scan_next;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              load_out;
  rsp_t              out_next;
  logic              out_free;
  logic              full;

  assign out_free = !rsp_valid || rsp_ready;
  assign full     = !empty && (head == wrap_inc(tail));

  always_comb begin
    state_next = state;
    head_next  = head;
    tail_next  = tail;
    empty_next = empty;
    scan_next  = scan;
    op_take    = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    rd_en      = 1'b0;
    rd_addr    = head;
    load_out   = 1'b0;
    out_next   = '0;
    out_next.last = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (op_valid && out_free) begin
          op_take = 1'b1;
          unique case (op.kind)
            OP_PUSH: begin
              load_out = 1'b1;
              if (full) begin
                out_next.status = ST_FULL;
              end else begin
                out_next.status = ST_OK;
                wr_en = 1'b1;
                if (empty) begin
                  head_next  = '0;
                  tail_next  = '0;
                  empty_next = 1'b0;
                  wr_addr    = '0;
                end else if (op.at_front) begin
                  head_next = wrap_dec(head);
                  wr_addr   = wrap_dec(head);
                end else begin
                  tail_next = wrap_inc(tail);
                  wr_addr   = wrap_inc(tail);
                end
              end
            end
            OP_POP: begin
              if (empty) begin
                load_out        = 1'b1;
                out_next.status = ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                state_next = S_POP;
                if (head == tail) begin
                  rd_addr    = head;
                  head_next  = '0;
                  tail_next  = '0;
                  empty_next = 1'b1;
                end else if (op.at_front) begin
                  rd_addr   = head;
                  head_next = wrap_inc(head);
                end else begin
                  rd_addr   = tail;
                  tail_next = wrap_dec(tail);
                end
              end
            end
            OP_READ: begin
              if (empty) begin
                load_out        = 1'b1;
                out_next.status = ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = head;
                scan_next  = head;
                state_next = S_SCAN;
              end
            end
            default: begin
              // No such kind comes out of the front end; the op is dropped.
            end
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          load_out          = 1'b1;
          out_next.data_out = rdata;
          out_next.status   = ST_OK;
          state_next        = S_IDLE;
        end
      end
      S_SCAN: begin
        if (out_free) begin
          load_out          = 1'b1;
          out_next.data_out = rdata;
          out_next.status   = ST_OK;
          out_next.last     = (scan == tail);
          if (scan == tail) begin
            state_next = S_IDLE;
          end else begin
            scan_next = wrap_inc(scan);
            rd_en     = 1'b1;
            rd_addr   = wrap_inc(scan);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= op.data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      empty     <= 1'b1;
      scan      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      empty <= empty_next;
      scan  <= scan_next;
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp <= out_next;
    end
  end

endmodule

@@ sv/circular_deque.sv @@
`timescale 1ns / 1ps

// A double-ended queue of signed 32-bit words held in a circular memory of
// DEPTH entries. Each request item carries one command: push at the front,
// push at the rear, pop from the front, pop from the rear, or read out every
// entry from head to tail. Pushes, pops and empty read-outs return one
// response item each; a full read-out returns one item per stored entry with
// last set on the tail entry. Codes five to seven are accepted and dropped.
// Pushes stream at one item per cycle while responses are taken. A pop and
// a read-out go through a further state, S_POP or S_SCAN, because the
// single memory read port has a registered output and the engine handles
// one command at a time. A two-entry command queue between the decoder and
// the engine keeps the request side accepting while the engine is busy. A
// response register holds each result until it is taken; the engine moves
// on only when that register is empty or is being emptied in the same cycle,
// so a receiver that holds off stalls the engine and, once the command queue
// is full, the request side.

module circular_deque #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  cdq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output cdq_pkg::rsp_t rsp
);
  import cdq_pkg::*;

  // Decoded commands travel from the front end to the engine.
  op_t  op;
  logic op_valid;
  logic op_take;

  cdq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .op_valid  (op_valid),
    .op_take   (op_take),
    .op        (op)
  );

  // The engine owns the memory, the head and tail indices and the empty
  // flag, and sequences read-outs one entry per cycle while responses are taken.
  cdq_engine #(
    .DEPTH (DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_take   (op_take),
    .op        (op),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import cdq_pkg::*;

  localparam int DEPTH = 16;
  localparam int RANDOM_ITEMS = 375;
  localparam int CYCLE_LIMIT = 200000;
  // Longest run of work inside the block: a full read-out plus pipeline slack.
  localparam int DRAIN_CYCLES = 64;
  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

  // Scoreboard for the deque: keeps its own copy of the entries and of the
  // head, tail and empty state, turns each accepted command into the responses
  // it must produce, and checks the responses in order as they arrive.
  class deque_checker;
    logic signed [DATA_W-1:0] slots[DEPTH];
    int head;
    int tail;
    bit empty;
    rsp_t awaited_rsps[$];
    int errors;

    function new();
      head = 0;
      tail = 0;
      empty = 1'b1;
      errors = 0;
    endfunction

    function int pending();
      return awaited_rsps.size();
    endfunction

    function rsp_t make_rsp(logic signed [DATA_W-1:0] word, logic [1:0] st, logic fin);
      rsp_t r;
      r.data_out = word;
      r.status = st;
      r.last = fin;
      return r;
    endfunction

    // Notes one accepted command and queues the responses that it causes.
    function void apply_command(req_t item);
      logic signed [DATA_W-1:0] word;
      int i;
      bit fin;
      case (item.cmd)
        CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
          if (!empty && head == (tail + 1) % DEPTH) begin
            awaited_rsps.push_back(make_rsp('0, ST_FULL, 1'b1));
          end else begin
            if (empty) begin
              head = 0;
              tail = 0;
              empty = 1'b0;
              slots[0] = item.data_in;
            end else if (item.cmd == CMD_PUSH_FRONT) begin
              head = (head + DEPTH - 1) % DEPTH;
              slots[head] = item.data_in;
            end else begin
              tail = (tail + 1) % DEPTH;
              slots[tail] = item.data_in;
            end
            awaited_rsps.push_back(make_rsp('0, ST_OK, 1'b1));
          end
        end
        CMD_POP_FRONT, CMD_POP_REAR: begin
          if (empty) begin
            awaited_rsps.push_back(make_rsp('0, ST_EMPTY, 1'b1));
          end else begin
            if (head == tail) begin
              word = slots[head];
              head = 0;
              tail = 0;
              empty = 1'b1;
            end else if (item.cmd == CMD_POP_FRONT) begin
              word = slots[head];
              head = (head + 1) % DEPTH;
            end else begin
              word = slots[tail];
              tail = (tail + DEPTH - 1) % DEPTH;
            end
            awaited_rsps.push_back(make_rsp(word, ST_OK, 1'b1));
          end
        end
        CMD_READ_ALL: begin
          if (empty) begin
            awaited_rsps.push_back(make_rsp('0, ST_EMPTY, 1'b1));
          end else begin
            i = head;
            for (int n = 0; n < DEPTH; n++) begin
              fin = (i == tail);
              awaited_rsps.push_back(make_rsp(slots[i], ST_OK, fin));
              if (fin) break;
              i = (i + 1) % DEPTH;
            end
          end
        end
        default: begin
        end
      endcase
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_response(rsp_t got);
      rsp_t want;
      if (awaited_rsps.size() == 0) begin
        report_mismatch($sformatf("response %h arrived with nothing awaited", got));
        return;
      end
      want = awaited_rsps.pop_front();
      if (got.data_out !== want.data_out)
        report_mismatch($sformatf("data_out got %h want %h", got.data_out, want.data_out));
      if (got.status !== want.status)
        report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.last !== want.last)
        report_mismatch($sformatf("last got %0b want %0b", got.last, want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  // Set by the sender while it runs a stretch of items with no gaps.
  bit sender_steady = 1'b0;
  int cycle_count = 0;

  deque_checker sb = new();

  circular_deque #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always #10 clk = ~clk;

  // Watchdog. The limit is many times the slowest legal run: every item a
  // full read-out, every response held back by the receiver, plus the long
  // hold-off below.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // One monitor for both channels. The response taken at an edge is checked
  // before the command taken at the same edge is noted, so the order of the
  // two never depends on how the simulator schedules separate processes.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) sb.check_response(rsp);
      if (req_valid && req_ready) sb.apply_command(req);
    end
  end

  // Receiver. It stalls about a quarter of the time, holds off entirely for
  // a long stretch once, so the command queue inside the block fills and
  // the request side stalls, and later takes a run of responses with no
  // stalls at all.
  initial begin
    int seen;
    int hold_left;
    bit held;
    seen = 0;
    hold_left = 0;
    held = 1'b0;
    rsp_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rsp_valid && rsp_ready) seen++;
      if (seen == 150 && !held) begin
        held = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (seen >= 420 && seen < 620) begin
        rsp_ready <= 1'b1;
      end else begin
        rsp_ready <= ($urandom_range(99) >= 27);
      end
      @(posedge clk);
    end
  end

  // Offers one item and returns at the edge where it is taken. Random gaps
  // come first; valid is never dropped while an item is on offer, and a
  // following call keeps it high unless it draws a gap first.
  task send_item(logic [2:0] cmd, logic signed [DATA_W-1:0] word);
    while (!sender_steady && $urandom_range(99) < 27) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req.cmd <= cmd;
    req.data_in <= word;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // Stops offering and waits until every awaited response has come. The
  // first edge lets the monitor note the item taken at the current edge.
  task wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Picks a random word, now and then one of the extremes.
  function logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(15))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int real_items;
    int r;
    int phase;
    logic [2:0] cmd;
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Every refusal on an empty queue comes first.
    send_item(CMD_READ_ALL, '0);
    send_item(CMD_POP_FRONT, WORD_MAX);
    send_item(CMD_POP_REAR, WORD_MIN);
    // Extreme words at both ends, then fill the queue to the brim.
    send_item(CMD_PUSH_FRONT, WORD_MAX);
    send_item(CMD_PUSH_REAR, WORD_MIN);
    send_item(CMD_PUSH_FRONT, '1);
    send_item(CMD_PUSH_REAR, '0);
    for (int k = 0; k < DEPTH - 4; k++)
      send_item((k % 2 == 0) ? CMD_PUSH_FRONT : CMD_PUSH_REAR, $urandom);
    // Pushes to a full queue are refused at either end.
    send_item(CMD_PUSH_FRONT, WORD_MIN);
    send_item(CMD_PUSH_REAR, WORD_MAX);
    // A read-out of a full queue gives one response per entry.
    send_item(CMD_READ_ALL, '1);
    // The unused codes must be taken and produce nothing.
    for (int k = 1; k <= 3; k++)
      send_item(CMD_READ_ALL + 3'(k), $urandom);

    // Random part. The mix swings between filling, draining and balanced
    // phases so the queue hits full and empty over and over, with wrapped
    // head and tail in between. Unused codes are sprinkled in but do not
    // count toward the item total.
    real_items = 0;
    while (real_items < RANDOM_ITEMS) begin
      phase = (real_items / 40) % 3;
      sender_steady = (real_items >= 100 && real_items < 200);
      if (real_items == 300) wait_drained();
      r = $urandom_range(99);
      if (r >= 97) begin
        cmd = CMD_READ_ALL + 3'($urandom_range(3, 1));
      end else if (r >= 87) begin
        cmd = CMD_READ_ALL;
      end else if (r < (phase == 0 ? 65 : (phase == 1 ? 20 : 43))) begin
        cmd = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
      end else begin
        cmd = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_REAR;
      end
      send_item(cmd, pick_word());
      if (cmd <= CMD_READ_ALL) real_items++;
    end
    sender_steady = 1'b0;

    // Let every awaited response come out, then give the block time to show
    // any stray response before the verdict.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
